// ----- design/qgg_pkg.sv -----
`timescale 1ns / 1ps

package qgg_pkg;

	localparam int unsigned PHASE_BITS_DEF      = 24;
	localparam int unsigned ANGLE_FRAC_BITS_DEF = 12;
	localparam int unsigned TICK_BITS_DEF       = 16;

	localparam int unsigned SWING_W = 14;
	localparam int unsigned LIFT_W  = 16;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned SPEED_W = 7;
	localparam int unsigned BASE_W  = 14;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned NUM_LEGS = 4;

	localparam logic [MODE_W-1:0] MODE_TROT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CRAWL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STILL = 2'd2;

	localparam logic [2:0] REG_GAIT_MODE  = 3'd0;
	localparam logic [2:0] REG_SPEED      = 3'd1;
	localparam logic [2:0] REG_BASE_FR    = 3'd2;
	localparam logic [2:0] REG_BASE_BR    = 3'd3;
	localparam logic [2:0] REG_BASE_FL    = 3'd4;
	localparam logic [2:0] REG_BASE_BL    = 3'd5;

	localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
	localparam logic [BASE_W-1:0]  BASE_RESET = 14'd6434;

	localparam logic [63:0] Q30_ONE       = 64'd1073741824;
	localparam logic [63:0] K_C1          = 64'd1686629713;
	localparam logic [63:0] K_C3          = 64'd693598668;
	localparam logic [63:0] K_C5          = 64'd85569306;
	localparam logic [63:0] K_C7          = 64'd5026995;
	localparam logic [63:0] K_C9          = 64'd172272;
	localparam logic [63:0] K_TWO_OVER_PI = 64'd683565276;
	localparam logic [31:0] RECIP_FIVE    = 32'hCCCCCCCD;
	localparam logic [31:0] RECIP_THREE   = 32'hAAAAAAAB;
	localparam logic [31:0] RECIP_FOUR    = 32'h80000000;
	localparam logic [27:0] TICK_DEN      = 28'd200000000;
	// floor(2^59 / TICK_DEN)
	localparam logic [31:0] RECIP_TICK    = 32'd2882303761;

	typedef struct packed {
		logic [MODE_W-1:0]                mode;
		logic [SPEED_W-1:0]               speed;
		logic [NUM_LEGS-1:0][BASE_W-1:0]  base;
	} cfg_t;

	typedef struct packed {
		logic        [SWING_W-1:0] swing_front_right;
		logic signed [LIFT_W-1:0]  lift_front_right;
		logic        [SWING_W-1:0] swing_back_right;
		logic signed [LIFT_W-1:0]  lift_back_right;
		logic        [SWING_W-1:0] swing_front_left;
		logic signed [LIFT_W-1:0]  lift_front_left;
		logic        [SWING_W-1:0] swing_back_left;
		logic signed [LIFT_W-1:0]  lift_back_left;
	} pose_t;

	function automatic logic [1:0] leg_quarter(input logic [MODE_W-1:0] mode,
			input logic [1:0] leg);
		logic [1:0] q;
		q = 2'd0;
		if (mode == MODE_TROT) begin
			case (leg)
				2'd0:    q = 2'd2;
				2'd3:    q = 2'd2;
				default: q = 2'd0;
			endcase
		end else begin
			case (leg)
				2'd0:    q = 2'd0;
				2'd1:    q = 2'd2;
				2'd2:    q = 2'd1;
				default: q = 2'd3;
			endcase
		end
		return q;
	endfunction

endpackage

// ----- design/qgg_ifs.sv -----
`timescale 1ns / 1ps

interface qgg_tick_if import qgg_pkg::*; #(
	parameter int unsigned TICK_BITS = TICK_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [TICK_BITS-1:0] elapsed_us;

	modport source (output valid, output elapsed_us, input ready);
	modport sink (input valid, input elapsed_us, output ready);
endinterface

interface qgg_pose_if import qgg_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic        [SWING_W-1:0] swing_front_right;
	logic signed [LIFT_W-1:0]  lift_front_right;
	logic        [SWING_W-1:0] swing_back_right;
	logic signed [LIFT_W-1:0]  lift_back_right;
	logic        [SWING_W-1:0] swing_front_left;
	logic signed [LIFT_W-1:0]  lift_front_left;
	logic        [SWING_W-1:0] swing_back_left;
	logic signed [LIFT_W-1:0]  lift_back_left;

	modport source (output valid, input ready,
		output swing_front_right, output lift_front_right,
		output swing_back_right, output lift_back_right,
		output swing_front_left, output lift_front_left,
		output swing_back_left, output lift_back_left);
	modport sink (input valid, output ready,
		input swing_front_right, input lift_front_right,
		input swing_back_right, input lift_back_right,
		input swing_front_left, input lift_front_left,
		input swing_back_left, input lift_back_left);
endinterface

// ----- design/qgg_regs.sv -----
`timescale 1ns / 1ps

module qgg_regs import qgg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_TROT;
			cfg_q.speed <= '0;
			cfg_q.base  <= {NUM_LEGS{BASE_RESET}};
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIT_MODE: cfg_q.mode    <= pwdata[MODE_W-1:0];
				REG_SPEED:     cfg_q.speed   <= pwdata[SPEED_W-1:0];
				REG_BASE_FR:   cfg_q.base[0] <= pwdata[BASE_W-1:0];
				REG_BASE_BR:   cfg_q.base[1] <= pwdata[BASE_W-1:0];
				REG_BASE_FL:   cfg_q.base[2] <= pwdata[BASE_W-1:0];
				REG_BASE_BL:   cfg_q.base[3] <= pwdata[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GAIT_MODE: prdata = DATA_W'(cfg_q.mode);
			REG_SPEED:     prdata = DATA_W'(cfg_q.speed);
			REG_BASE_FR:   prdata = DATA_W'(cfg_q.base[0]);
			REG_BASE_BR:   prdata = DATA_W'(cfg_q.base[1]);
			REG_BASE_FL:   prdata = DATA_W'(cfg_q.base[2]);
			REG_BASE_BL:   prdata = DATA_W'(cfg_q.base[3]);
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- design/qgg_mul.sv -----
`timescale 1ns / 1ps

module qgg_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

endmodule

// ----- design/qgg_seq.sv -----
`timescale 1ns / 1ps

module qgg_seq import qgg_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int unsigned TICK_BITS       = TICK_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TICK_BITS-1:0] in_elapsed,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pose_t                out_pose
);

	localparam int unsigned PB  = PHASE_BITS;
	localparam int unsigned AF  = ANGLE_FRAC_BITS;
	localparam int unsigned NW  = SPEED_W + TICK_BITS;
	localparam int unsigned SH  = 59 - PB;
	localparam int unsigned KW  = PB + 3;
	localparam int unsigned UW  = PB + 33;
	localparam int unsigned VW  = PB + AF + 4;
	localparam int unsigned TW  = AF + 4;
	localparam int unsigned SW  = AF + 2;
	localparam int unsigned HW  = AF + 1;
	localparam logic [63:0] HP64 = (K_C1 + (64'd1 << (29 - AF))) >> (30 - AF);
	localparam logic [HW-1:0] HP = HP64[HW-1:0];
	localparam logic [31:0] RND = 32'd1 << (29 - AF);
	localparam logic [30:0] ONE = Q30_ONE[30:0];
	localparam logic [31:0] TWO_ONE = 32'd2147483648;

	typedef enum logic [17:0] {
		S_IDLE     = 18'b000000000000000001,
		S_INC_MUL  = 18'b000000000000000010,
		S_INC_LOAD = 18'b000000000000000100,
		S_INC_EST  = 18'b000000000000001000,
		S_INC_REM  = 18'b000000000000010000,
		S_INC_FIX  = 18'b000000000000100000,
		S_LEG      = 18'b000000000001000000,
		S_SIN_DONE = 18'b000000000010000000,
		S_COS_DONE = 18'b000000000100000000,
		S_Y_FIN    = 18'b000000001000000000,
		S_AS_CHK   = 18'b000000010000000000,
		S_AS_X     = 18'b000000100000000000,
		S_AS_CMP   = 18'b000001000000000000,
		S_SQ       = 18'b000010000000000000,
		S_RET_MUL  = 18'b000100000000000000,
		S_RET_FIN  = 18'b001000000000000000,
		S_EMIT     = 18'b010000000000000000,
		S_DONE     = 18'b100000000000000000
	} state_t;

	state_t state_q, sq_ret_q;

	logic [TICK_BITS-1:0]      el_q;
	logic [NW-1:0]             n_q;
	logic [63:0]               rem_q;
	logic [31:0]               quo_q;
	logic [PB-1:0]             phase_q;
	logic [1:0]                leg_q;
	logic [2:0]                sq_step_q;
	logic [30:0]               x_q;
	logic [31:0]               x2_q;
	logic [30:0]               sq_q;
	logic [30:0]               w_q;
	logic                      neg_q;
	logic [30:0]               s_q;
	logic [30:0]               y_q;
	logic [HW-1:0]             lo_q, hi_q, mid_q;
	logic [TW-1:0]             t_q;
	logic signed [SW-1:0]      stride_q;
	logic [HW-1:0]             height_q;
	logic [NUM_LEGS-1:0][SWING_W-1:0] sw_q;
	logic [NUM_LEGS-1:0][LIFT_W-1:0]  lf_q;
	logic                      out_valid_q;
	pose_t                     pose_q;

	logic [31:0]               mul_a, mul_b;
	logic [63:0]               p_q;
	logic [SPEED_W-1:0]        spd;
	logic                      trot;
	logic [31:0]               q_est;
	logic                      rem_ge;
	logic [PB-1:0]             p_leg;
	logic [KW-1:0]             kp;
	logic                      swing;
	logic [UW-1:0]             uw;
	logic [30:0]               w;
	logic [KW-1:0]             d;
	logic [VW-1:0]             v;
	logic [31:0]               x2p;
	logic [31:0]               coef;
	logic [31:0]               sq_raw;
	logic [31:0]               mag;
	logic [HW:0]               mid_sum;
	logic [63:0]               x_as;
	logic [31:0]               y_sum;
	logic [SW:0]               ret_q;
	logic signed [31:0]        sw32, lf32;
	logic                      load_out;

	assign spd      = (cfg.speed > SPEED_MAX) ? SPEED_MAX : cfg.speed;
	assign trot     = (cfg.mode == MODE_TROT);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_pose  = pose_q;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// phase step estimate by reciprocal multiply, never above the exact quotient
	assign q_est  = 32'(p_q >> SH);
	assign rem_ge = (rem_q >= 64'(TICK_DEN));

	assign p_leg = phase_q + {leg_quarter(cfg.mode, leg_q), {(PB-2){1'b0}}};
	assign kp    = trot ? {p_leg, 2'b00} : ({p_leg, 2'b00} + KW'(p_leg));
	assign swing = (kp[KW-1:PB] == '0);
	assign uw    = {KW'(kp), 30'd0} >> PB;
	assign w     = {uw[29:0], 1'b0};
	assign d     = kp - (KW'(1) << PB);
	assign v     = (VW'(d) << (AF + 1)) + (VW'(trot ? 3 : 4) << (PB - 1));

	assign x2p     = p_q[61:30];
	assign sq_raw  = p_q[61:30];
	assign mag     = (32'(sq_q) + RND) >> (30 - AF);
	assign mid_sum = (HW+1)'(lo_q) + (HW+1)'(hi_q) + (HW+1)'(1);
	assign x_as    = p_q >> AF;
	assign y_sum   = 32'(s_q) + 32'(p_q[63:34]);
	assign ret_q   = (SW+1)'(p_q[AF+34:33]) - ((SW+1)'(1) << AF);

	always_comb begin
		coef = 32'(K_C9);
		case (sq_step_q)
			3'd2:    coef = 32'(K_C7);
			3'd3:    coef = 32'(K_C5);
			3'd4:    coef = 32'(K_C3);
			3'd5:    coef = 32'(K_C1);
			default: coef = 32'(K_C9);
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_INC_MUL: begin
				mul_a = 32'(spd);
				mul_b = 32'(el_q);
			end
			S_INC_LOAD: begin
				mul_a = 32'(p_q[NW-1:0]);
				mul_b = RECIP_TICK;
			end
			S_INC_EST: begin
				mul_a = q_est;
				mul_b = 32'(TICK_DEN);
			end
			S_SQ: begin
				case (sq_step_q)
					3'd0: begin
						mul_a = 32'(x_q);
						mul_b = 32'(x_q);
					end
					3'd1: begin
						mul_a = coef;
						mul_b = x2p;
					end
					3'd2, 3'd3, 3'd4: begin
						mul_a = coef - x2p;
						mul_b = x2_q;
					end
					3'd5: begin
						mul_a = coef - x2p;
						mul_b = 32'(x_q);
					end
					default: ;
				endcase
			end
			S_COS_DONE: begin
				mul_a = {s_q, 1'b0} + 32'(s_q);
				mul_b = RECIP_FIVE;
			end
			S_AS_CHK: begin
				mul_a = 32'(mid_sum[HW:1]);
				mul_b = 32'(K_TWO_OVER_PI);
			end
			S_RET_MUL: begin
				mul_a = 32'(t_q);
				mul_b = trot ? RECIP_THREE : RECIP_FOUR;
			end
			default: ;
		endcase
	end

	qgg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	always_comb begin
		sw32 = 32'(HP) + (leg_q[1] ? -32'(stride_q) : 32'(stride_q));
		lf32 = leg_q[1] ? (32'(cfg.base[leg_q]) + 32'(height_q))
			: (32'(cfg.base[leg_q]) - 32'(height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sq_ret_q    <= S_IDLE;
			phase_q     <= '0;
			leg_q       <= '0;
			sq_step_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !cfg.mode[1]) begin
						state_q <= S_INC_MUL;
					end
				end
				S_INC_MUL:  state_q <= S_INC_LOAD;
				S_INC_LOAD: state_q <= S_INC_EST;
				S_INC_EST:  state_q <= S_INC_REM;
				S_INC_REM:  state_q <= S_INC_FIX;
				S_INC_FIX: begin
					if (!rem_ge) begin
						phase_q <= phase_q + quo_q[PB-1:0];
						leg_q   <= '0;
						state_q <= S_LEG;
					end
				end
				S_LEG: begin
					if (swing) begin
						sq_step_q <= '0;
						sq_ret_q  <= S_SIN_DONE;
						state_q   <= S_SQ;
					end else begin
						state_q <= S_RET_MUL;
					end
				end
				S_SQ: begin
					sq_step_q <= sq_step_q + 3'd1;
					if (sq_step_q == 3'd6) begin
						state_q <= sq_ret_q;
					end
				end
				S_SIN_DONE: begin
					sq_step_q <= '0;
					sq_ret_q  <= S_COS_DONE;
					state_q   <= S_SQ;
				end
				S_COS_DONE: state_q <= S_Y_FIN;
				S_Y_FIN:    state_q <= S_AS_CHK;
				S_AS_CHK: begin
					state_q <= (lo_q == hi_q) ? S_EMIT : S_AS_X;
				end
				S_AS_X: begin
					sq_step_q <= '0;
					sq_ret_q  <= S_AS_CMP;
					state_q   <= S_SQ;
				end
				S_AS_CMP:  state_q <= S_AS_CHK;
				S_RET_MUL: state_q <= S_RET_FIN;
				S_RET_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					leg_q <= leg_q + 2'd1;
					state_q <= (leg_q == 2'd3) ? S_DONE : S_LEG;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: el_q <= in_elapsed;
			S_INC_LOAD: begin
				n_q <= p_q[NW-1:0];
			end
			S_INC_EST: begin
				quo_q <= q_est;
			end
			S_INC_REM: begin
				rem_q <= (64'(n_q) << PB) - p_q;
			end
			S_INC_FIX: begin
				if (rem_ge) begin
					rem_q <= rem_q - 64'(TICK_DEN);
					quo_q <= quo_q + 32'd1;
				end
			end
			S_LEG: begin
				x_q <= (w <= ONE) ? w : 31'(TWO_ONE - 32'(w));
				w_q <= w;
				t_q <= v[PB+TW-1:PB];
			end
			S_SQ: begin
				if (sq_step_q == 3'd1) begin
					x2_q <= x2p;
				end
				if (sq_step_q == 3'd6) begin
					sq_q <= (sq_raw > 32'(ONE)) ? ONE : sq_raw[30:0];
				end
			end
			S_SIN_DONE: begin
				s_q   <= sq_q;
				neg_q <= (w_q > ONE);
				x_q   <= (w_q > ONE) ? (w_q - ONE) : (ONE - w_q);
			end
			S_COS_DONE: begin
				stride_q <= neg_q ? -SW'(mag) : SW'(mag);
			end
			S_Y_FIN: begin
				y_q  <= (y_sum > 32'(ONE)) ? ONE : y_sum[30:0];
				lo_q <= '0;
				hi_q <= HP;
			end
			S_AS_CHK: begin
				mid_q    <= mid_sum[HW:1];
				height_q <= lo_q;
			end
			S_AS_X: begin
				x_q <= (x_as > 64'(ONE)) ? ONE : x_as[30:0];
			end
			S_AS_CMP: begin
				if (sq_q <= y_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q - HW'(1);
				end
			end
			S_RET_FIN: begin
				stride_q <= ret_q[SW-1:0];
				height_q <= '0;
			end
			S_EMIT: begin
				sw_q[leg_q] <= sw32[SWING_W-1:0];
				lf_q[leg_q] <= lf32[LIFT_W-1:0];
			end
			S_DONE: begin
				if (load_out) begin
					pose_q.swing_front_right <= sw_q[0];
					pose_q.lift_front_right  <= lf_q[0];
					pose_q.swing_back_right  <= sw_q[1];
					pose_q.lift_back_right   <= lf_q[1];
					pose_q.swing_front_left  <= sw_q[2];
					pose_q.lift_front_left   <= lf_q[2];
					pose_q.swing_back_left   <= sw_q[3];
					pose_q.lift_back_left    <= lf_q[3];
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- design/quadruped_gait_generator_top.sv -----
`timescale 1ns / 1ps

// quadruped gait generator
// tick channel (valid/ready): one request per control tick carrying the
// microseconds elapsed since the previous tick
// pose channel (valid/ready): eight servo angles, radians * 2^ANGLE_FRAC_BITS,
// one result per tick in trot or crawl mode, none in still mode
// apb port: gait mode, speed and four base angles at byte offsets 0..20
// a tick first computes the phase step: reciprocal multiply,
// back multiply and at most one correction step with default widths
// each leg then uses the shared 32x32 multiplier, in the return part and in
// the swing part, whose arcsine search takes 12 or 13 steps
// the pose is registered once all four legs are done
// tick ready is high only while the sequencer is idle, so the next tick is
// taken in the cycle after the pose is registered; a still-mode tick is
// taken and dropped
// the finished pose waits in an output register; a stalled receiver holds
// it and the next tick is still taken, finishing only when the register frees
// reset clears the phase, sets trot mode, speed 0 and base angles 6434

module quadruped_gait_generator_top import qgg_pkg::*; #(
	parameter int unsigned PHASE_BITS      = PHASE_BITS_DEF,
	parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int unsigned TICK_BITS       = TICK_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	qgg_tick_if.sink          tick,
	qgg_pose_if.source        pose,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t  cfg;
	pose_t pose_d;

	qgg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qgg_seq #(
		.PHASE_BITS      (PHASE_BITS),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.TICK_BITS       (TICK_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (tick.valid),
		.in_ready   (tick.ready),
		.in_elapsed (tick.elapsed_us),
		.out_valid  (pose.valid),
		.out_ready  (pose.ready),
		.out_pose   (pose_d)
	);

	assign pose.swing_front_right = pose_d.swing_front_right;
	assign pose.lift_front_right  = pose_d.lift_front_right;
	assign pose.swing_back_right  = pose_d.swing_back_right;
	assign pose.lift_back_right   = pose_d.lift_back_right;
	assign pose.swing_front_left  = pose_d.swing_front_left;
	assign pose.lift_front_left   = pose_d.lift_front_left;
	assign pose.swing_back_left   = pose_d.swing_back_left;
	assign pose.lift_back_left    = pose_d.lift_back_left;

endmodule

// ----- design/qgg_checker.sv -----
`timescale 1ns / 1ps

module qgg_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         tick_valid,
	input logic         tick_ready,
	input logic         pose_valid,
	input logic         pose_ready,
	input logic [119:0] pose_bits
);

	a_pose_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_ready |=> pose_valid)
		else $error("pose request dropped while stalled");

	a_pose_stable: assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && !pose_ready |=> $stable(pose_bits))
		else $error("pose payload changed while stalled");

	a_pose_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose_valid) |-> !$past(tick_ready))
		else $error("pose appeared while sequencer was idle");

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(tick_ready) |-> $past(tick_valid))
		else $error("sequencer went busy without a tick request");

endmodule

bind quadruped_gait_generator_top qgg_checker u_qgg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.pose_valid (pose.valid),
	.pose_ready (pose.ready),
	.pose_bits  ({pose.swing_front_right, pose.lift_front_right,
		pose.swing_back_right, pose.lift_back_right,
		pose.swing_front_left, pose.lift_front_left,
		pose.swing_back_left, pose.lift_back_left})
);

// ----- tb/quadruped_gait_generator_top_tb.sv -----
`timescale 1ns / 1ps

class pose_scoreboard;
	localparam logic [63:0] PHASE_ONE  = 64'd1 << 24;
	localparam logic [63:0] PHASE_MASK = (64'd1 << 24) - 64'd1;
	localparam logic [63:0] SWING_MASK = 64'h3FFF;
	localparam logic [63:0] LIFT_MASK  = 64'hFFFF;

	logic [63:0] gait_phase = 0;
	logic [1:0] mode = qgg_pkg::MODE_TROT;
	logic [6:0] speed = 0;
	logic [13:0] base[4] = '{default: qgg_pkg::BASE_RESET};
	qgg_pkg::pose_t pending_poses[$];
	int errors = 0;

	function void set_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			qgg_pkg::REG_GAIT_MODE: mode = val[1:0];
			qgg_pkg::REG_SPEED: speed = val[6:0];
			qgg_pkg::REG_BASE_FR: base[0] = val[13:0];
			qgg_pkg::REG_BASE_BR: base[1] = val[13:0];
			qgg_pkg::REG_BASE_FL: base[2] = val[13:0];
			default: base[3] = val[13:0];
		endcase
	endfunction

	function logic [63:0] quarter_sine(logic [63:0] x);
		logic [63:0] x2, r, s;
		if (x > qgg_pkg::Q30_ONE)
			x = qgg_pkg::Q30_ONE;
		x2 = (x * x) >> 30;
		r = qgg_pkg::K_C9;
		r = qgg_pkg::K_C7 - ((r * x2) >> 30);
		r = qgg_pkg::K_C5 - ((r * x2) >> 30);
		r = qgg_pkg::K_C3 - ((r * x2) >> 30);
		r = qgg_pkg::K_C1 - ((r * x2) >> 30);
		s = (r * x) >> 30;
		return (s > qgg_pkg::Q30_ONE) ? qgg_pkg::Q30_ONE : s;
	endfunction

	function logic [63:0] lift_arcsine(logic [63:0] y, logic [63:0] half_pi);
		logic [63:0] lo, hi, mid, x;
		lo = 0;
		hi = half_pi;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			x = (mid * qgg_pkg::K_TWO_OVER_PI) >> 12;
			if (quarter_sine(x) <= y)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	function longint round_to_angle(longint v);
		logic [63:0] mag;
		longint r;
		mag = (v < 0) ? -v : v;
		r = longint'((mag + (64'd1 << 17)) >> 18);
		return (v < 0) ? -r : r;
	endfunction

	function void note_tick(logic [15:0] elapsed);
		logic [63:0] spd, inc, k, half_pi, p, kp, u, w, s, y, num, den;
		logic [1:0] q;
		longint t, c, stride, height;
		logic [13:0] sw[4];
		logic [15:0] lf[4];
		qgg_pkg::pose_t pz;
		if (mode >= qgg_pkg::MODE_STILL)
			return;
		spd = (speed > qgg_pkg::SPEED_MAX) ? 64'd100 : 64'(speed);
		inc = ((spd * 64'(elapsed)) << 24) / 64'd200000000;
		gait_phase = (gait_phase + inc) & PHASE_MASK;
		k = (mode == qgg_pkg::MODE_TROT) ? 64'd4 : 64'd5;
		half_pi = (qgg_pkg::K_C1 + (64'd1 << 17)) >> 18;
		for (int i = 0; i < 4; i++) begin
			if (mode == qgg_pkg::MODE_TROT)
				q = (i == 0 || i == 3) ? 2'd2 : 2'd0;
			else
				q = (i == 0) ? 2'd0 : (i == 1) ? 2'd2 : (i == 2) ? 2'd1 : 2'd3;
			p = (gait_phase + (64'(q) << 22)) & PHASE_MASK;
			kp = k * p;
			if (kp < PHASE_ONE) begin
				u = (kp << 30) >> 24;
				w = 2 * u;
				s = (w <= qgg_pkg::Q30_ONE) ? quarter_sine(w)
					: quarter_sine(2 * qgg_pkg::Q30_ONE - w);
				t = longint'(qgg_pkg::Q30_ONE) - longint'(w);
				c = (t < 0) ? -longint'(quarter_sine(-t)) : longint'(quarter_sine(t));
				stride = round_to_angle(c);
				y = (s * 8) / 5;
				if (y > qgg_pkg::Q30_ONE)
					y = qgg_pkg::Q30_ONE;
				height = longint'(lift_arcsine(y, half_pi));
			end else begin
				num = (kp - PHASE_ONE) << 13;
				den = (k - 1) << 24;
				stride = longint'((num + den / 2) / den) - 4096;
				height = 0;
			end
			if (i < 2) begin
				sw[i] = 14'(longint'(half_pi) + stride);
				lf[i] = 16'(longint'(base[i]) - height);
			end else begin
				sw[i] = 14'(longint'(half_pi) - stride);
				lf[i] = 16'(longint'(base[i]) + height);
			end
		end
		pz = '{sw[0], lf[0], sw[1], lf[1], sw[2], lf[2], sw[3], lf[3]};
		pending_poses.push_back(pz);
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task compare_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task check_pose(qgg_pkg::pose_t got);
		qgg_pkg::pose_t want;
		if (pending_poses.size() == 0) begin
			report("pose with no tick pending");
			return;
		end
		want = pending_poses.pop_front();
		compare_field("swing_front_right", got.swing_front_right, want.swing_front_right);
		compare_field("lift_front_right", got.lift_front_right, want.lift_front_right);
		compare_field("swing_back_right", got.swing_back_right, want.swing_back_right);
		compare_field("lift_back_right", got.lift_back_right, want.lift_back_right);
		compare_field("swing_front_left", got.swing_front_left, want.swing_front_left);
		compare_field("lift_front_left", got.lift_front_left, want.lift_front_left);
		compare_field("swing_back_left", got.swing_back_left, want.swing_back_left);
		compare_field("lift_back_left", got.lift_back_left, want.lift_back_left);
	endtask
endclass

module quadruped_gait_generator_top_tb;
	import qgg_pkg::*;

	localparam int DRAIN_CYCLES = 1000;
	localparam longint CYCLE_LIMIT = 20000000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [ADDR_W-1:0] paddr = 0;
	logic [DATA_W-1:0] pwdata = 0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	bit idle_on = 0;
	bit hold_off_req = 0;
	int hold_left = 0;
	int stall_left = 0;
	longint cycles = 0;
	pose_scoreboard sb = new();

	qgg_tick_if tick_bus();
	qgg_pose_if pose_bus();

	quadruped_gait_generator_top uut (
		.clk(clk), .arst_n(arst_n), .tick(tick_bus.sink), .pose(pose_bus.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	initial begin
		tick_bus.valid = 0;
		tick_bus.elapsed_us = 0;
		pose_bus.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pose_bus.valid && pose_bus.ready) begin
				sb.check_pose('{pose_bus.swing_front_right, pose_bus.lift_front_right,
					pose_bus.swing_back_right, pose_bus.lift_back_right,
					pose_bus.swing_front_left, pose_bus.lift_front_left,
					pose_bus.swing_back_left, pose_bus.lift_back_left});
				stall_left = idle_on ? $urandom_range(0, 11) : 0;
			end
			if (hold_off_req) begin
				hold_off_req = 0;
				hold_left = 4000;
			end
			if (hold_left > 0) begin
				hold_left--;
				pose_bus.ready <= 0;
			end else if (stall_left > 0) begin
				stall_left--;
				pose_bus.ready <= 0;
			end else begin
				pose_bus.ready <= 1;
			end
		end
	end

	task write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_reg(idx, val);
	endtask

	task configure(logic [1:0] m, logic [6:0] spd, logic [13:0] b0, logic [13:0] b1,
			logic [13:0] b2, logic [13:0] b3);
		write_reg(REG_GAIT_MODE, 32'(m));
		write_reg(REG_SPEED, 32'(spd));
		write_reg(REG_BASE_FR, 32'(b0));
		write_reg(REG_BASE_BR, 32'(b1));
		write_reg(REG_BASE_FL, 32'(b2));
		write_reg(REG_BASE_BL, 32'(b3));
	endtask

	task send_tick(logic [15:0] el);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			tick_bus.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		tick_bus.valid <= 1;
		tick_bus.elapsed_us <= el;
		@(posedge clk);
		while (!tick_bus.ready)
			@(posedge clk);
		sb.note_tick(el);
	endtask

	task drain();
		tick_bus.valid <= 0;
		@(posedge clk);
		while (sb.pending_poses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function logic [15:0] random_elapsed();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return 16'($urandom_range(0, 255));
		else if (sel == 3)
			return 16'hFFFF;
		else if (sel == 4)
			return 16'($urandom_range(0, 20000));
		return 16'($urandom);
	endfunction

	function logic [13:0] random_base();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0)
			return 14'd0;
		else if (sel == 1)
			return 14'd12868;
		else if (sel == 2)
			return 14'h3FFF;
		return 14'($urandom);
	endfunction

	initial begin
		logic [1:0] m;
		logic [6:0] spd;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values, phase stays at zero
		send_tick(16'd0);
		send_tick(16'hFFFF);
		drain();
		configure(MODE_TROT, 7'd100, 14'd0, 14'd12868, 14'h3FFF, 14'd6434);
		send_tick(16'd0);
		send_tick(16'd1);
		send_tick(16'hFFFF);
		send_tick(16'h8000);
		send_tick(16'h5555);
		send_tick(16'hAAAA);
		drain();
		// speed saturates above one hundred
		configure(MODE_CRAWL, 7'd127, 14'h3FFF, 14'd0, 14'd12868, 14'd1);
		for (int i = 0; i < 8; i++)
			send_tick(16'd6250);
		drain();
		configure(MODE_STILL, 7'd50, 14'd6434, 14'd6434, 14'd6434, 14'd6434);
		send_tick(16'hFFFF);
		send_tick(16'd1234);
		drain();
		write_reg(REG_GAIT_MODE, 32'd3);
		send_tick(16'hFFFF);
		send_tick(16'd0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			n = $urandom_range(0, 5);
			m = (n == 0) ? MODE_STILL : (n == 1) ? 2'd3 : (n < 4) ? MODE_TROT : MODE_CRAWL;
			if (ph < 2)
				m = MODE_TROT;
			else if (ph < 4)
				m = MODE_CRAWL;
			n = $urandom_range(0, 4);
			spd = (n == 0) ? 7'd100 : (n == 1) ? 7'd127 : (n == 2) ? 7'd0 : 7'($urandom);
			if (ph == 3)
				spd = 7'd1;
			configure(m, spd, random_base(), random_base(), random_base(), random_base());
			idle_on = (ph % 3) != 0;
			if (ph == 1)
				hold_off_req = 1;
			n = (m >= MODE_STILL) ? 20 : 140;
			for (int i = 0; i < n; i++)
				send_tick(random_elapsed());
			drain();
		end

		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- quadruped_gait_generator_top.f -----
design/qgg_pkg.sv
design/qgg_ifs.sv
design/qgg_regs.sv
design/qgg_mul.sv
design/qgg_seq.sv
design/quadruped_gait_generator_top.sv
design/qgg_checker.sv
tb/quadruped_gait_generator_top_tb.sv
